FILE: rtl/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types, codes and constants of the drum step sequencer.
// ----------------------------------------------------------------------------
package dss_pkg;

	// Q8 fraction word, 256 means one
	typedef logic [8:0] q8_t;

	// Input operation codes
	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_RETRIG  = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;
	localparam logic [1:0] OP_WRITE   = 2'd3;

	// Step entry fields
	localparam int NFLD = 7;
	localparam logic [2:0] FLD_ENABLE   = 3'd0;
	localparam logic [2:0] FLD_VOLUME   = 3'd1;
	localparam logic [2:0] FLD_PITCH    = 3'd2;
	localparam logic [2:0] FLD_LENGTH   = 3'd3;
	localparam logic [2:0] FLD_DURATION = 3'd4;
	localparam logic [2:0] FLD_CURVE_A  = 3'd5;
	localparam logic [2:0] FLD_CURVE_B  = 3'd6;

	// Play modes
	localparam logic [1:0] MODE_FWD  = 2'd0;
	localparam logic [1:0] MODE_PING = 2'd1;
	localparam logic [1:0] MODE_REV  = 2'd2;
	localparam logic [1:0] MODE_RAND = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] REG_BEAT = 2'd0;
	localparam logic [1:0] REG_TICK = 2'd1;
	localparam logic [1:0] REG_LAST = 2'd2;
	localparam logic [1:0] REG_MODE = 2'd3;

	// Constants of the envelope
	localparam q8_t         Q8_ONE   = 9'd256;
	localparam q8_t         Q8_HALF  = 9'd128;
	localparam logic [11:0] LEN_BASE = 12'd2816;
	localparam q8_t         P_MAX    = 9'd230;
	localparam logic [15:0] LFSR_SEED = 16'hACE1;

	// Serial divider widths
	localparam int DIV_NW = 32;
	localparam int DIV_DW = 26;
	localparam int DIV_CW = 6;

	typedef struct packed {
		logic              start;
		logic [DIV_CW-1:0] nbits;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
		logic [DIV_DW-1:0] rem0;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_NW-1:0] quo;
		logic [DIV_DW-1:0] rem;
	} div_rsp_t;

	// Step length in quarter beats by duration class
	function automatic logic [4:0] quarter_beats(input logic [2:0] di);
		logic [4:0] r;
		case (di)
			3'd0: r = 5'd1;
			3'd1: r = 5'd2;
			3'd2: r = 5'd4;
			3'd3: r = 5'd8;
			3'd4: r = 5'd12;
			default: r = 5'd16;
		endcase
		return r;
	endfunction

	// Value of a step field before it is first written
	function automatic q8_t field_reset(input logic [2:0] f);
		q8_t r;
		case (f)
			FLD_VOLUME:   r = Q8_ONE;
			FLD_PITCH:    r = Q8_HALF;
			FLD_LENGTH:   r = Q8_ONE;
			FLD_DURATION: r = Q8_HALF;
			default:      r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/dss_ram.sv
// ----------------------------------------------------------------------------
// dss_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dss_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and read the array
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/dss_div.sv
// ----------------------------------------------------------------------------
// dss_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dss_div (
	input  logic              clk,
	input  logic              arst_n,
	input  dss_pkg::div_req_t req,
	output dss_pkg::div_rsp_t rsp
);

	logic                       busy_q;
	logic                       done_q;
	logic [dss_pkg::DIV_CW-1:0] cnt_q;
	logic [dss_pkg::DIV_DW-1:0] r_q;
	logic [dss_pkg::DIV_NW-1:0] q_q;
	logic [dss_pkg::DIV_DW-1:0] den_q;
	logic [dss_pkg::DIV_DW:0]   trial;
	logic                       qbit;
	logic [dss_pkg::DIV_DW-1:0] r_next;

	// Trial subtract of the shifted partial remainder
	always_comb begin
		trial  = {r_q, q_q[dss_pkg::DIV_NW-1]};
		qbit   = (trial >= {1'b0, den_q});
		r_next = qbit ? dss_pkg::DIV_DW'(trial - {1'b0, den_q})
			: trial[dss_pkg::DIV_DW-1:0];
	end

	// Load on start, then shift one bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == dss_pkg::DIV_CW'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == dss_pkg::DIV_CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q   <= req.rem0;
			q_q   <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			r_q <= r_next;
			q_q <= {q_q[dss_pkg::DIV_NW-2:0], qbit};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = q_q;
	assign rsp.rem  = r_q;

endmodule

FILE: rtl/drum_step_sequencer.sv
// ----------------------------------------------------------------------------
// drum_step_sequencer
// Step sequencer with per-step parameters, four play modes and an envelope.
// ----------------------------------------------------------------------------
// One input word gives one result word, and a new word is taken only once the
// previous one has gone through; a stalled receiver holds the block before it
// goes idle. Nearly all of the work is done by the shared bit-serial divider,
// which finds the envelope period, the elapsed time modulo that period, the
// progress fraction (skipped when that remainder is at least twice the beat)
// and, for a tick that advances in random mode, the random step. Step
// parameters live in one RAM per field with valid bits, so no clearing pass
// follows reset.
// Configuration is taken only while no word is in progress.
module drum_step_sequencer #(
	parameter int STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [3:0]  entry_index,
	input  logic [2:0]  field_select,
	input  logic [8:0]  value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  step_index,
	output logic        advanced,
	output logic        trigger,
	output logic [8:0]  pitch_out,
	output logic [8:0]  gain_out,
	output logic [8:0]  curve_a_out,
	output logic [8:0]  curve_b_out
);

	localparam int AW = (STEPS > 1) ? $clog2(STEPS) : 1;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_APPLY = 4'd1;
	localparam logic [3:0] S_RD    = 4'd2;
	localparam logic [3:0] S_CHK   = 4'd3;
	localparam logic [3:0] S_RND   = 4'd4;
	localparam logic [3:0] S_MUL   = 4'd5;
	localparam logic [3:0] S_L5    = 4'd6;
	localparam logic [3:0] S_W5    = 4'd7;
	localparam logic [3:0] S_LM    = 4'd8;
	localparam logic [3:0] S_WM    = 4'd9;
	localparam logic [3:0] S_LP    = 4'd10;
	localparam logic [3:0] S_WP    = 4'd11;
	localparam logic [3:0] S_GAIN  = 4'd12;
	localparam logic [3:0] S_OUT   = 4'd13;

	// Configuration registers
	logic [23:0] beat_q;
	logic [15:0] tick_q;
	logic [3:0]  last_q;
	logic [1:0]  mode_q;

	// Sequencer state
	logic [3:0]  state_q;
	logic [31:0] elapsed_q;
	logic [3:0]  cur_q;
	logic        down_q;
	logic        retrig_q;
	logic [15:0] lfsr_q;
	logic        chk_done_q;
	logic        adv_q;
	logic        trig_q;

	// Latched item
	logic [1:0]  op_q;
	logic [3:0]  idx_q;
	logic [2:0]  sel_q;
	dss_pkg::q8_t val_q;

	// Envelope datapath
	logic [35:0]  x_q;
	logic [25:0]  mod_q;
	logic [25:0]  rem_q;
	logic         pz_q;
	dss_pkg::q8_t p_q;
	dss_pkg::q8_t gain_q;

	// Step field storage
	logic [STEPS-1:0] vld_q [dss_pkg::NFLD];
	logic             vld_rd_q [dss_pkg::NFLD];
	dss_pkg::q8_t     rd_raw [dss_pkg::NFLD];
	dss_pkg::q8_t     fld [dss_pkg::NFLD];
	logic             wr_ok;

	dss_pkg::div_req_t div_req;
	dss_pkg::div_rsp_t div_rsp;

	logic [23:0] beat_eff;
	logic [3:0]  top;
	logic [10:0] d5;
	logic [2:0]  di;
	logic [28:0] need;
	logic        hit;
	logic [4:0]  cur_inc;
	logic [3:0]  nxt_cur;
	logic        nxt_down;
	logic        nxt_retrig;
	logic [15:0] lfsr_next;
	logic [32:0] sum;
	logic [11:0] kmul;
	logic [25:0] q5;
	logic [17:0] gprod;

	assign cfg_ready = (state_q == S_IDLE);
	assign in_ready  = (state_q == S_IDLE);
	assign wr_ok     = (state_q == S_APPLY) && (op_q == dss_pkg::OP_WRITE)
		&& ({3'b0, idx_q} < 7'(STEPS));

	// One RAM per step field, valid bits stand in for the reset values
	for (genvar f = 0; f < dss_pkg::NFLD; f++) begin : g_fld
		localparam int FW = (f == 0) ? 1 : 9;
		logic          we_f;
		logic [FW-1:0] wd_f;
		logic [FW-1:0] rd_f;

		assign we_f = wr_ok && (sel_q == 3'(f));
		assign wd_f = (f == 0) ? FW'(val_q > dss_pkg::Q8_HALF) : FW'(val_q);

		dss_ram #(.WIDTH(FW), .DEPTH(STEPS)) u_ram (
			.clk  (clk),
			.we   (we_f),
			.waddr(AW'(idx_q)),
			.wdata(wd_f),
			.raddr(AW'(cur_q)),
			.rdata(rd_f)
		);

		assign rd_raw[f] = 9'(rd_f);
		assign fld[f]    = vld_rd_q[f] ? rd_raw[f] : dss_pkg::field_reset(3'(f));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[f]    <= '0;
				vld_rd_q[f] <= 1'b0;
			end else begin
				if (we_f) begin
					vld_q[f][AW'(idx_q)] <= 1'b1;
				end
				vld_rd_q[f] <= vld_q[f][AW'(cur_q)];
			end
		end
	end

	dss_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// Advance test and next-step selection
	always_comb begin
		beat_eff  = (beat_q == 24'd0) ? 24'd1 : beat_q;
		top       = ({3'b0, last_q} > 7'(STEPS - 1)) ? 4'(STEPS - 1) : last_q;
		d5        = 11'(fld[dss_pkg::FLD_DURATION] * 4'd5);
		di        = (d5[10:8] > 3'd5) ? 3'd5 : d5[10:8];
		need      = 29'(beat_eff * dss_pkg::quarter_beats(di));
		hit       = ({elapsed_q, 2'b00} >= 34'(need)) || retrig_q;
		sum       = {1'b0, elapsed_q} + 33'(tick_q);
		lfsr_next = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};
		cur_inc   = {1'b0, cur_q} + 5'd1;

		nxt_cur    = cur_q;
		nxt_down   = down_q;
		nxt_retrig = retrig_q;
		case (mode_q)
			dss_pkg::MODE_FWD: begin
				if (cur_inc > {1'b0, top} || retrig_q) begin
					nxt_cur    = 4'd0;
					nxt_retrig = 1'b0;
				end else begin
					nxt_cur = cur_inc[3:0];
				end
			end
			dss_pkg::MODE_PING: begin
				if (!down_q) begin
					if (cur_inc > {1'b0, top}) begin
						nxt_cur  = top;
						nxt_down = 1'b1;
					end else if (retrig_q) begin
						nxt_cur    = 4'd0;
						nxt_down   = 1'b0;
						nxt_retrig = 1'b0;
					end else begin
						nxt_cur = cur_inc[3:0];
					end
				end else begin
					if (cur_q != 4'd0 && (cur_q - 4'd1) > top) begin
						nxt_cur  = top;
						nxt_down = 1'b1;
					end else if (cur_q == 4'd0 || retrig_q) begin
						nxt_cur    = 4'd0;
						nxt_down   = 1'b0;
						nxt_retrig = 1'b0;
					end else begin
						nxt_cur = cur_q - 4'd1;
					end
				end
			end
			dss_pkg::MODE_REV: begin
				if (cur_q == 4'd0 || retrig_q) begin
					nxt_cur    = top;
					nxt_retrig = 1'b0;
				end else begin
					nxt_cur = cur_q - 4'd1;
				end
			end
			default: begin
				nxt_retrig = 1'b0;
			end
		endcase

		kmul  = dss_pkg::LEN_BASE - 12'(fld[dss_pkg::FLD_LENGTH] * 4'd10);
		q5    = div_rsp.quo[25:0];
		gprod = 18'((dss_pkg::Q8_ONE - p_q) * fld[dss_pkg::FLD_VOLUME]);
	end

	// Launch the shared divider
	always_comb begin
		div_req = '0;
		div_req.den = 26'd1;
		case (state_q)
			S_CHK: begin
				if (chk_done_q == 1'b0 && op_q == dss_pkg::OP_TICK && hit
					&& mode_q == dss_pkg::MODE_RAND) begin
					div_req.start = 1'b1;
					div_req.nbits = 6'd16;
					div_req.num   = {lfsr_next, 16'd0};
					div_req.den   = 26'({1'b0, top} + 5'd1);
				end
			end
			S_L5: begin
				div_req.start = 1'b1;
				div_req.nbits = 6'd27;
				div_req.num   = {x_q[35:9], 5'd0};
				div_req.den   = 26'd5;
			end
			S_LM: begin
				div_req.start = 1'b1;
				div_req.nbits = 6'd32;
				div_req.num   = elapsed_q;
				div_req.den   = mod_q;
			end
			S_LP: begin
				if (rem_q < {1'b0, beat_eff, 1'b0}) begin
					div_req.start = 1'b1;
					div_req.nbits = 6'd9;
					div_req.num   = {rem_q[0], 31'd0};
					div_req.den   = 26'(beat_eff);
					div_req.rem0  = {1'b0, rem_q[25:1]};
				end
			end
			default: begin
			end
		endcase
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q <= 24'd27429;
			tick_q <= 16'd1486;
			last_q <= 4'd15;
			mode_q <= dss_pkg::MODE_FWD;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dss_pkg::REG_BEAT: beat_q <= cfg_data;
				dss_pkg::REG_TICK: tick_q <= cfg_data[15:0];
				dss_pkg::REG_LAST: last_q <= cfg_data[3:0];
				dss_pkg::REG_MODE: mode_q <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	// Item sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			elapsed_q  <= '0;
			cur_q      <= '0;
			down_q     <= 1'b0;
			retrig_q   <= 1'b0;
			lfsr_q     <= dss_pkg::LFSR_SEED;
			chk_done_q <= 1'b0;
			adv_q      <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			// Drop a taken word unless a new one replaces it
			if (out_valid && out_ready && state_q != S_OUT) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q    <= S_APPLY;
						chk_done_q <= 1'b0;
						adv_q      <= 1'b0;
					end
				end
				S_APPLY: begin
					case (op_q)
						dss_pkg::OP_TICK: begin
							elapsed_q <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
						end
						dss_pkg::OP_RETRIG: begin
							cur_q    <= 4'd0;
							retrig_q <= 1'b1;
						end
						dss_pkg::OP_RESTART: begin
							elapsed_q <= '0;
							cur_q     <= 4'd0;
						end
						default: begin
						end
					endcase
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= (op_q == dss_pkg::OP_TICK && !chk_done_q) ? S_CHK : S_MUL;
				end
				S_CHK: begin
					chk_done_q <= 1'b1;
					if (hit) begin
						elapsed_q <= '0;
						adv_q     <= 1'b1;
						down_q    <= nxt_down;
						retrig_q  <= nxt_retrig;
						if (mode_q == dss_pkg::MODE_RAND) begin
							lfsr_q  <= lfsr_next;
							state_q <= S_RND;
						end else begin
							cur_q   <= nxt_cur;
							state_q <= S_RD;
						end
					end else begin
						state_q <= S_MUL;
					end
				end
				S_RND: begin
					if (div_rsp.done) begin
						cur_q   <= div_rsp.rem[3:0];
						state_q <= S_RD;
					end
				end
				S_MUL:  state_q <= S_L5;
				S_L5:   state_q <= S_W5;
				S_W5:   if (div_rsp.done) state_q <= S_LM;
				S_LM:   state_q <= S_WM;
				S_WM:   if (div_rsp.done) state_q <= S_LP;
				S_LP:   state_q <= div_req.start ? S_WP : S_GAIN;
				S_WP:   if (div_rsp.done) state_q <= S_GAIN;
				S_GAIN: state_q <= S_OUT;
				S_OUT: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q  <= op;
			idx_q <= entry_index;
			sel_q <= field_select;
			val_q <= (value > dss_pkg::Q8_ONE) ? dss_pkg::Q8_ONE : value;
		end
		if (state_q == S_MUL) begin
			x_q    <= 36'(beat_eff * kmul);
			trig_q <= adv_q && fld[dss_pkg::FLD_ENABLE][0];
		end
		if (state_q == S_W5 && div_rsp.done) begin
			mod_q <= (q5 < 26'd256) ? 26'd256 : q5;
		end
		if (state_q == S_WM && div_rsp.done) begin
			rem_q <= div_rsp.rem;
		end
		if (state_q == S_LP) begin
			pz_q <= !div_req.start;
		end
		if (state_q == S_WP && div_rsp.done) begin
			p_q <= div_rsp.quo[8:0];
		end
		if (state_q == S_GAIN) begin
			gain_q <= (pz_q || p_q > dss_pkg::P_MAX) ? 9'd0 : gprod[16:8];
		end
		if (state_q == S_OUT && (!out_valid || out_ready)) begin
			step_index  <= cur_q;
			advanced    <= adv_q;
			trigger     <= trig_q;
			pitch_out   <= fld[dss_pkg::FLD_PITCH];
			gain_out    <= gain_q;
			curve_a_out <= fld[dss_pkg::FLD_CURVE_A];
			curve_b_out <= fld[dss_pkg::FLD_CURVE_B];
		end
	end

endmodule

FILE: rtl/dss_chk.sv
// ----------------------------------------------------------------------------
// dss_chk
// Port-level checks of the drum step sequencer result words.
// ----------------------------------------------------------------------------
module dss_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] step_index,
	input logic       advanced,
	input logic       trigger,
	input logic [8:0] pitch_out,
	input logic [8:0] gain_out
);

	// A trigger only comes when the step advances
	a_trig_adv: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!trigger || advanced))
		else $error("trigger without advance");

	// Gain and pitch stay within one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (gain_out <= 9'd256 && pitch_out <= 9'd256))
		else $error("Q8 output above one");

	// A stalled result word holds its step index and gain
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(step_index)
			&& $stable(gain_out))
		else $error("result word changed while stalled");

endmodule

bind drum_step_sequencer dss_chk u_dss_chk (.*);
